// ----- rtl/lz8_pkg.sv -----
// shared types and constants for the eight-mode lz decompressor
// no dependencies; used by lz8_window_ram, lz8_cmd_ctrl and the top level
package lz8_pkg;

    localparam int WIN_BITS  = 16;                // window address width, 8..16
    localparam int WIN_DEPTH = 1 << WIN_BITS;

    localparam logic [7:0] END_HDR  = 8'hFF;
    localparam logic [2:0] LONG_CMD = 3'b111;

    localparam logic [2:0] CMD_LITERAL  = 3'd0;
    localparam logic [2:0] CMD_FILL     = 3'd1;
    localparam logic [2:0] CMD_ALT_FILL = 3'd2;
    localparam logic [2:0] CMD_INC_FILL = 3'd3;
    localparam logic [2:0] CMD_COPY     = 3'd4;
    localparam logic [2:0] CMD_COPY_INV = 3'd5;
    localparam logic [2:0] CMD_BACK     = 3'd6;
    localparam logic [2:0] CMD_BACK_INV = 3'd7;

    typedef logic [WIN_BITS-1:0] t_waddr;

    // per-transfer result of the command stage, completed after the window read
    typedef struct packed {
        logic       taken;
        logic       out_valid;
        logic       stream_end;
        logic       is_copy;
        logic       invert;
        logic [7:0] data;
        t_waddr     addr;
    } t_emit;

endpackage

// ----- rtl/lz8_window_ram.sv -----
// window memory: one write port, one registered read port, read-first
// depends on lz8_pkg for the window size
module lz8_window_ram (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  lz8_pkg::t_waddr     i_rd_addr,
    output logic [7:0]          o_rd_data,
    input  logic                i_wr_en,
    input  lz8_pkg::t_waddr     i_wr_addr,
    input  logic [7:0]          i_wr_data
);

    logic [7:0] r_mem [lz8_pkg::WIN_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lz8_cmd_ctrl.sv -----
// command parser: header, length and argument decode, fill generation,
// write and copy positions; depends on lz8_pkg
module lz8_cmd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_byte_valid,
    input  logic [7:0]          i_in_byte,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    output lz8_pkg::t_emit      o_emit,
    output lz8_pkg::t_waddr     o_rd_addr
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LONGLEN = 3'd1;
    localparam logic [2:0] PH_ARG1    = 3'd2;
    localparam logic [2:0] PH_ARG2    = 3'd3;
    localparam logic [2:0] PH_EMIT    = 3'd4;
    localparam logic [2:0] PH_LITERAL = 3'd5;

    logic [2:0]      r_phase, n_phase;
    logic [2:0]      r_kind, n_kind;
    logic [10:0]     r_rc, n_rc;
    logic [7:0]      r_first, n_first;
    logic [7:0]      r_second, n_second;
    logic            r_toggle, n_toggle;
    lz8_pkg::t_waddr r_cp, n_cp;
    lz8_pkg::t_waddr r_wp, n_wp;
    logic [15:0]     r_base, n_base;
    logic            emit;
    logic [15:0]     abs_sum;
    lz8_pkg::t_emit  e;

    assign abs_sum = r_base + {i_in_byte, r_first};

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_rc     = r_rc;
        n_first  = r_first;
        n_second = r_second;
        n_toggle = r_toggle;
        n_cp     = r_cp;
        n_wp     = r_wp;
        n_base   = r_base;
        emit     = 1'b0;
        e        = '0;
        e.addr   = r_wp;
        if (i_step) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_byte_valid) begin
                        e.taken = 1'b1;
                        if (i_in_byte == lz8_pkg::END_HDR) begin
                            e.stream_end = 1'b1;
                            n_wp = r_base[lz8_pkg::WIN_BITS-1:0];
                        end else if (i_in_byte[7:5] == lz8_pkg::LONG_CMD) begin
                            n_kind  = i_in_byte[4:2];
                            n_rc    = {1'b0, i_in_byte[1:0], 8'd0};
                            n_phase = PH_LONGLEN;
                        end else begin
                            n_kind   = i_in_byte[7:5];
                            n_rc     = 11'(i_in_byte[4:0]) + 11'd1;
                            n_toggle = 1'b0;
                            n_phase  = (i_in_byte[7:5] == lz8_pkg::CMD_LITERAL) ?
                                       PH_LITERAL : PH_ARG1;
                        end
                    end
                end
                PH_LONGLEN: begin
                    if (i_byte_valid) begin
                        e.taken  = 1'b1;
                        n_rc     = {1'b0, r_rc[9:8], i_in_byte} + 11'd1;
                        n_toggle = 1'b0;
                        n_phase  = (r_kind == lz8_pkg::CMD_LITERAL) ? PH_LITERAL : PH_ARG1;
                    end
                end
                PH_ARG1: begin
                    if (i_byte_valid) begin
                        e.taken = 1'b1;
                        case (r_kind)
                            lz8_pkg::CMD_ALT_FILL, lz8_pkg::CMD_COPY,
                            lz8_pkg::CMD_COPY_INV: begin
                                n_first = i_in_byte;
                                n_cp    = lz8_pkg::WIN_BITS'(i_in_byte);
                                n_phase = PH_ARG2;
                            end
                            lz8_pkg::CMD_BACK, lz8_pkg::CMD_BACK_INV: begin
                                n_cp    = r_wp - lz8_pkg::WIN_BITS'(i_in_byte);
                                n_phase = PH_EMIT;
                            end
                            default: begin
                                n_first = i_in_byte;
                                n_phase = PH_EMIT;
                            end
                        endcase
                    end
                end
                PH_ARG2: begin
                    if (i_byte_valid) begin
                        e.taken = 1'b1;
                        if (r_kind == lz8_pkg::CMD_ALT_FILL) begin
                            n_second = i_in_byte;
                        end else begin
                            n_cp = abs_sum[lz8_pkg::WIN_BITS-1:0];
                        end
                        n_phase = PH_EMIT;
                    end
                end
                PH_EMIT: begin
                    emit = 1'b1;
                    case (r_kind)
                        lz8_pkg::CMD_COPY, lz8_pkg::CMD_COPY_INV,
                        lz8_pkg::CMD_BACK, lz8_pkg::CMD_BACK_INV: begin
                            // byte value comes from the registered window read, in the completion stage
                            e.is_copy = 1'b1;
                            e.invert  = r_kind[0];
                            n_cp      = r_cp + lz8_pkg::t_waddr'(1);
                        end
                        lz8_pkg::CMD_ALT_FILL: begin
                            e.data   = r_toggle ? r_second : r_first;
                            n_toggle = ~r_toggle;
                        end
                        lz8_pkg::CMD_INC_FILL: begin
                            e.data  = r_first;
                            n_first = r_first + 8'd1;
                        end
                        default: begin
                            e.data = r_first;
                        end
                    endcase
                end
                PH_LITERAL: begin
                    if (i_byte_valid) begin
                        e.taken = 1'b1;
                        e.data  = i_in_byte;
                        emit    = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
            if (emit) begin
                e.out_valid = 1'b1;
                n_wp        = r_wp + lz8_pkg::t_waddr'(1);
                if (r_rc <= 11'd1) begin
                    n_rc    = '0;
                    n_phase = PH_HEADER;
                end else begin
                    n_rc = r_rc - 11'd1;
                end
            end
        end
        if (i_cfg_wr_en) begin
            n_base = i_cfg_wr_data;
            if (r_phase == PH_HEADER) begin
                n_wp = i_cfg_wr_data[lz8_pkg::WIN_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_kind   <= '0;
            r_rc     <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_toggle <= 1'b0;
            r_cp     <= '0;
            r_wp     <= '0;
            r_base   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_rc     <= n_rc;
            r_first  <= n_first;
            r_second <= n_second;
            r_toggle <= n_toggle;
            r_cp     <= n_cp;
            r_wp     <= n_wp;
            r_base   <= n_base;
        end
    end

    assign o_emit    = e;
    assign o_rd_addr = r_cp;

endmodule

// ----- rtl/lz_eight_mode_decompressor_unit.sv -----
// top level of the eight-mode lz decompressor: command stage, window memory,
// copy completion stage and output register; depends on lz8_pkg, lz8_cmd_ctrl, lz8_window_ram
//
// usage
//   slave channel: one transfer per tick, carrying an optional compressed byte
//     (byte_valid flag and the byte). every accepted transfer yields exactly one
//     master transfer, in order, telling whether the byte was consumed and
//     whether a decompressed byte was written to the window (and where).
//   the upstream side must re-offer a byte that comes back with byte_taken low
//     (fills and copies emit without consuming).
//   pipeline: two register stages; a result shows on the master side after its input
//     transfer passes the command stage, the read/completion register and the output register.
//   throughput: one transfer per cycle while the master side does not stall; the window read
//     is issued in the command stage and its data used in the completion stage, with the byte
//     written by the previous transfer forwarded when the addresses match.
//   stall: when the master side holds a result and tready is low, the whole
//     pipe freezes and s_axis_tready drops in the same cycle.
//   reset: synchronous active low; parser waits for a header, write position
//     and base address return to zero. window contents are not cleared.
//   configuration: i_cfg_wr_en writes base_addr; write only while idle.
module lz_eight_mode_decompressor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // byte_valid[0], in_byte[8:1], zero[15:9]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // byte_taken[0], out_valid[1], out_byte[9:2],
                                          // out_addr[25:10], stream_end[26], zero[31:27]
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data     // base_addr
);

    logic            w_adv;        // pipe moves this cycle
    logic            w_step;       // input transfer accepted
    lz8_pkg::t_emit  w_emit;
    lz8_pkg::t_waddr w_rd_addr;
    logic [7:0]      w_rd_data;
    logic [7:0]      w_src;        // window byte after forwarding
    logic [7:0]      w_value;      // final output byte of the completion stage
    logic            w_wr_en;
    logic [31:0]     w_packed;

    logic            r_b_valid;    // completion stage holds a transfer
    lz8_pkg::t_emit  r_b;
    logic            r_fwd_hit;    // read overlapped the write of the prior transfer
    logic [7:0]      r_fwd_data;
    logic            r_out_valid;
    logic [31:0]     r_out_data;

    // output register frees up when empty or being drained
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_step          = w_adv && i_s_axis_tvalid;
    assign o_s_axis_tready = w_adv;

    lz8_cmd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte_valid  (i_s_axis_tdata[0]),
        .i_in_byte     (i_s_axis_tdata[8:1]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_emit        (w_emit),
        .o_rd_addr     (w_rd_addr)
    );

    // copy byte: forwarded value if the previous transfer wrote the same entry
    assign w_src   = r_fwd_hit ? r_fwd_data : w_rd_data;
    assign w_value = r_b.is_copy ? (w_src ^ {8{r_b.invert}}) : r_b.data;
    assign w_wr_en = w_adv && r_b_valid && r_b.out_valid;

    lz8_window_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_b.addr),
        .i_wr_data (w_value)
    );

    // unused output fields read as zero when no byte is produced
    assign w_packed = {5'd0,
                       r_b.stream_end,
                       r_b.out_valid ? 16'(r_b.addr) : 16'd0,
                       r_b.out_valid ? w_value : 8'd0,
                       r_b.out_valid,
                       r_b.taken};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid   <= w_step;
            r_fwd_hit   <= w_wr_en && (w_rd_addr == r_b.addr);
            r_out_valid <= r_b_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b        <= w_emit;
            r_fwd_data <= w_value;
            r_out_data <= w_packed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // a window write always shows up as a produced byte in the next cycle
    a_write_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (o_m_axis_tvalid && o_m_axis_tdata[1]))
        else $error("window write without produced byte");

    // no produced byte means zero byte and address fields
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[1]) |-> (o_m_axis_tdata[25:2] == 24'd0))
        else $error("byte or address set without produced byte");

    // end header is consumed and never emits
    a_end_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[26]) |-> (o_m_axis_tdata[0] && !o_m_axis_tdata[1]))
        else $error("stream end without consumed byte");

    // a stall freezes the completion stage and its forwarding state
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_b_valid) && $stable(r_fwd_hit)))
        else $error("completion stage moved during stall");

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for lz_eight_mode_decompressor_unit: streams of all eight commands
// with random handshake gaps, every result checked against an in-bench decoder model
// depends on lz8_pkg and the rtl of the decompressor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES   = 6;     // margin over the result pipeline of the dut
    localparam int PHASE_BUDGET   = 50;    // items per random phase, five phases

    // parser states of the decoder model
    typedef enum logic [2:0] {
        ST_WAIT_HDR,
        ST_LEN_LO,
        ST_ARG_A,
        ST_ARG_B,
        ST_EMIT,
        ST_LITERAL
    } t_parse_state;

    // one master transfer, unpacked
    typedef struct packed {
        logic        taken;
        logic        produced;
        logic [7:0]  data;
        logic [15:0] addr;
        logic        done;
    } t_tick_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;    // byte_valid[0], in_byte[8:1], zero[15:9]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;         // byte_taken[0], out_valid[1], out_byte[9:2],
                                         // out_addr[25:10], stream_end[26], zero[31:27]
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;     // base_addr

    lz_eight_mode_decompressor_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder model: own copy of the window and parser state, advanced once
    // per accepted slave transfer
    // ------------------------------------------------------------------
    logic [7:0]      win_copy [lz8_pkg::WIN_DEPTH];
    logic [15:0]     base_q    = '0;
    lz8_pkg::t_waddr wr_pos    = '0;
    lz8_pkg::t_waddr src_pos   = '0;
    t_parse_state    pstate    = ST_WAIT_HDR;
    logic [2:0]      cmd_q     = '0;
    logic [10:0]     left_cnt  = '0;
    logic [7:0]      fill_a    = '0;
    logic [7:0]      fill_b    = '0;
    logic            alt_sel   = 1'b0;

    t_tick_result expected_ticks [$];    // results still owed by the dut, oldest first
    int           err_cnt = 0;

    function automatic t_tick_result decompress_tick(input logic have, input logic [7:0] b);
        t_tick_result r;
        logic [7:0]   v;
        logic         put;
        r   = '0;
        v   = '0;
        put = 1'b0;
        case (pstate)
            ST_WAIT_HDR: if (have) begin
                r.taken = 1'b1;
                if (b == lz8_pkg::END_HDR) begin
                    // end of stream: next stream starts again at the base
                    r.done = 1'b1;
                    wr_pos = lz8_pkg::t_waddr'(base_q);
                end else if (b[7:5] == lz8_pkg::LONG_CMD) begin
                    // long form: command in bits 4..2, length high bits in 1..0
                    cmd_q    = b[4:2];
                    left_cnt = {1'b0, b[1:0], 8'h00};
                    pstate   = ST_LEN_LO;
                end else begin
                    cmd_q    = b[7:5];
                    left_cnt = 11'(b[4:0]) + 11'd1;
                    pstate   = (cmd_q == lz8_pkg::CMD_LITERAL) ? ST_LITERAL : ST_ARG_A;
                    alt_sel  = 1'b0;
                end
            end
            ST_LEN_LO: if (have) begin
                r.taken  = 1'b1;
                left_cnt = {left_cnt[10:8], b} + 11'd1;
                pstate   = (cmd_q == lz8_pkg::CMD_LITERAL) ? ST_LITERAL : ST_ARG_A;
                alt_sel  = 1'b0;
            end
            ST_ARG_A: if (have) begin
                r.taken = 1'b1;
                if (cmd_q == lz8_pkg::CMD_ALT_FILL || cmd_q == lz8_pkg::CMD_COPY ||
                    cmd_q == lz8_pkg::CMD_COPY_INV) begin
                    fill_a  = b;
                    src_pos = lz8_pkg::t_waddr'(b);
                    pstate  = ST_ARG_B;
                end else if (cmd_q >= lz8_pkg::CMD_BACK) begin
                    src_pos = wr_pos - lz8_pkg::t_waddr'(b);
                    pstate  = ST_EMIT;
                end else begin
                    fill_a = b;
                    pstate = ST_EMIT;
                end
            end
            ST_ARG_B: if (have) begin
                r.taken = 1'b1;
                if (cmd_q == lz8_pkg::CMD_ALT_FILL) begin
                    fill_b = b;
                end else begin
                    // absolute copy: offset is relative to the base address
                    src_pos = lz8_pkg::t_waddr'(base_q + {b, src_pos[7:0]});
                end
                pstate = ST_EMIT;
            end
            ST_EMIT: begin
                // fills and copies never consume the offered byte
                put = 1'b1;
                if (cmd_q >= lz8_pkg::CMD_COPY) begin
                    // odd copy kinds are the inverted ones
                    v       = win_copy[src_pos] ^ {8{cmd_q[0]}};
                    src_pos = src_pos + lz8_pkg::t_waddr'(1);
                end else if (cmd_q == lz8_pkg::CMD_ALT_FILL) begin
                    v       = alt_sel ? fill_b : fill_a;
                    alt_sel = ~alt_sel;
                end else if (cmd_q == lz8_pkg::CMD_INC_FILL) begin
                    v      = fill_a;
                    fill_a = fill_a + 8'd1;
                end else begin
                    v = fill_a;
                end
            end
            ST_LITERAL: if (have) begin
                r.taken = 1'b1;
                put     = 1'b1;
                v       = b;
            end
            default: pstate = ST_WAIT_HDR;
        endcase
        if (put) begin
            r.produced       = 1'b1;
            r.data           = v;
            r.addr           = 16'(wr_pos);
            win_copy[wr_pos] = v;
            wr_pos           = wr_pos + lz8_pkg::t_waddr'(1);
            if (left_cnt <= 11'd1) begin
                left_cnt = '0;
                pstate   = ST_WAIT_HDR;
            end else begin
                left_cnt = left_cnt - 11'd1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stream builder: runs ahead of the dut, tracks where the stream will
    // write so copies only ever read window entries already written
    // ------------------------------------------------------------------
    logic [7:0]      comp_bytes [$];     // compressed bytes not yet consumed
    bit              wr_seen [lz8_pkg::WIN_DEPTH];
    logic [15:0]     gen_base = '0;
    lz8_pkg::t_waddr gen_wpos = '0;
    lz8_pkg::t_waddr dest_hist [$];      // recent command destinations, copy sources
    int              gen_items;

    task automatic queue_byte(input logic [7:0] b);
        comp_bytes.push_back(b);
        gen_items++;
    endtask

    task automatic end_stream();
        queue_byte(lz8_pkg::END_HDR);
        gen_wpos = lz8_pkg::t_waddr'(gen_base);
    endtask

    // src is the window address a copy reads first; for backward copies it
    // must lie within 255 bytes behind the write position
    task automatic add_command(input logic [2:0] cmd_in, input int len_in, input bit long_in,
                               input lz8_pkg::t_waddr src, input logic [7:0] arg_a,
                               input logic [7:0] arg_b);
        logic [2:0]  cmd;
        int          len;
        int          n;
        logic [9:0]  lenm1;
        logic [15:0] off;
        cmd = cmd_in;
        len = len_in;
        // long inverted backward copy with length bits 11 would read as the end header
        if (cmd == lz8_pkg::CMD_BACK_INV && len > 768)
            len = 768;
        if (cmd >= lz8_pkg::CMD_COPY) begin
            // cut the copy where it would read an entry never written,
            // counting entries this copy writes itself
            n = 0;
            while (n < len && (wr_seen[lz8_pkg::t_waddr'(src + n)] ||
                               lz8_pkg::t_waddr'(src + n - gen_wpos) < n))
                n++;
            if (n == 0)
                cmd = lz8_pkg::CMD_FILL;
            else
                len = n;
        end
        lenm1 = 10'(len - 1);
        if (long_in || cmd == lz8_pkg::CMD_BACK_INV || len > 32) begin
            queue_byte({lz8_pkg::LONG_CMD, cmd, lenm1[9:8]});
            queue_byte(lenm1[7:0]);
        end else begin
            queue_byte({cmd, lenm1[4:0]});
        end
        case (cmd)
            lz8_pkg::CMD_LITERAL: repeat (len) queue_byte(8'($urandom));
            lz8_pkg::CMD_FILL, lz8_pkg::CMD_INC_FILL: queue_byte(arg_a);
            lz8_pkg::CMD_ALT_FILL: begin
                queue_byte(arg_a);
                queue_byte(arg_b);
            end
            lz8_pkg::CMD_COPY, lz8_pkg::CMD_COPY_INV: begin
                off = 16'(src - lz8_pkg::t_waddr'(gen_base));
                queue_byte(off[7:0]);
                queue_byte(off[15:8]);
            end
            default: queue_byte(8'(gen_wpos - src));
        endcase
        if (cmd != lz8_pkg::CMD_LITERAL)
            gen_items += len;
        dest_hist.push_back(gen_wpos);
        if (dest_hist.size() > 16)
            dest_hist.delete(0);
        repeat (len) begin
            wr_seen[gen_wpos] = 1'b1;
            gen_wpos          = gen_wpos + lz8_pkg::t_waddr'(1);
        end
    endtask

    task automatic add_random_command();
        logic [2:0]      cmd;
        int              len;
        int              pick;
        lz8_pkg::t_waddr src;
        cmd  = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 59);
        // mostly short commands, now and then one with a long length
        if (pick == 0)
            len = $urandom_range(257, 1024);
        else if (pick < 12)
            len = $urandom_range(1, 32);
        else
            len = $urandom_range(1, 8);
        if (cmd == lz8_pkg::CMD_COPY || cmd == lz8_pkg::CMD_COPY_INV) begin
            if (dest_hist.size() > 0 && $urandom_range(0, 2) == 0)
                src = dest_hist[$urandom_range(0, dest_hist.size() - 1)];
            else
                src = gen_wpos - lz8_pkg::t_waddr'($urandom_range(1, 600));
        end else begin
            src = gen_wpos - lz8_pkg::t_waddr'($urandom_range(0, 255));
        end
        add_command(cmd, len, $urandom_range(0, 3) == 0, src, 8'($urandom), 8'($urandom));
    endtask

    // streams of random commands, most closed by an end header
    task automatic add_random_phase(input int budget);
        int n;
        gen_items = 0;
        while (gen_items < budget) begin
            n = $urandom_range(0, 8);
            repeat (n) add_random_command();
            if ($urandom_range(0, 9) != 0)
                end_stream();
        end
    endtask

    // base register write, only with the block idle in front of a header
    task automatic write_base(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        base_q = value;
        if (pstate == ST_WAIT_HDR)
            wr_pos = lz8_pkg::t_waddr'(value);
        gen_base = value;
        gen_wpos = lz8_pkg::t_waddr'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        // stream bytes are queued at a rising edge, away from the driver
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (comp_bytes.size() != 0 || pstate != ST_WAIT_HDR || expected_ticks.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // slave side driver: bursts of transfers with random gaps; a transfer
    // is held until accepted
    // ------------------------------------------------------------------
    logic s_fired = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !s_fired)) begin
            if (gap_left > 0) begin
                gap_left        <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (comp_bytes.size() > 0 || pstate == ST_EMIT) begin
                // an emitting command needs ticks even when no byte is left
                i_s_axis_tvalid <= 1'b1;
                if (comp_bytes.size() > 0 && $urandom_range(0, 7) != 0)
                    i_s_axis_tdata <= {7'd0, comp_bytes[0], 1'b1};
                else if (comp_bytes.size() > 0)
                    i_s_axis_tdata <= {7'd0, 8'($urandom), 1'b0};   // no byte offered
                else
                    i_s_axis_tdata <= {7'd0, 8'($urandom), 1'($urandom_range(0, 1))};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // master side: ready follows the bits of an 8-bit mask in turn, and the mask is replaced
    // whenever the 5-bit index wraps; a third of the masks never stall
    logic [7:0] ready_mask = 8'hFF;
    logic [4:0] ready_idx = '0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ready_mask[ready_idx[2:0]];
            ready_idx       <= ready_idx + 5'd1;
            if (ready_idx == 5'd31)
                ready_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
    end

    // ------------------------------------------------------------------
    // monitor: check master transfers, then advance the model on slave ones
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tick_result want;
        t_tick_result got;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.taken    = o_m_axis_tdata[0];
            got.produced = o_m_axis_tdata[1];
            got.data     = o_m_axis_tdata[9:2];
            got.addr     = o_m_axis_tdata[25:10];
            got.done     = o_m_axis_tdata[26];
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected transfer", o_m_axis_tdata, '0);
            end else begin
                want = expected_ticks.pop_front();
                if (got.taken !== want.taken)
                    report_mismatch("byte_taken", 32'(got.taken), 32'(want.taken));
                if (got.produced !== want.produced)
                    report_mismatch("out_valid", 32'(got.produced), 32'(want.produced));
                if (got.data !== want.data)
                    report_mismatch("out_byte", 32'(got.data), 32'(want.data));
                if (got.addr !== want.addr)
                    report_mismatch("out_addr", 32'(got.addr), 32'(want.addr));
                if (got.done !== want.done)
                    report_mismatch("stream_end", 32'(got.done), 32'(want.done));
            end
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            want = decompress_tick(i_s_axis_tdata[0], i_s_axis_tdata[8:1]);
            expected_ticks.push_back(want);
            if (want.taken)
                comp_bytes.delete(0);
        end
        s_fired <= i_s_axis_tvalid && o_s_axis_tready;
    end

    // watchdog: too long without any transfer on either side ends the run
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, two directed phases, then random phases over
    // several base addresses including both extremes
    // ------------------------------------------------------------------
    initial begin
        int          i;
        logic [15:0] rnd_base;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every command kind, fill data extremes, incrementing fill wrapping past 0xff,
        // and a long-form length past 256
        write_base(16'h0000);
        add_command(lz8_pkg::CMD_LITERAL, 32, 1'b0, '0, 8'h00, 8'h00);
        add_command(lz8_pkg::CMD_FILL, 1, 1'b0, '0, 8'hFF, 8'h00);
        add_command(lz8_pkg::CMD_ALT_FILL, 5, 1'b0, '0, 8'h00, 8'hFF);
        add_command(lz8_pkg::CMD_INC_FILL, 4, 1'b0, '0, 8'hFE, 8'h00);
        add_command(lz8_pkg::CMD_COPY, 8, 1'b0, lz8_pkg::t_waddr'(0), 8'h00, 8'h00);
        add_command(lz8_pkg::CMD_COPY_INV, 8, 1'b1, lz8_pkg::t_waddr'(16'h0010),
                    8'h00, 8'h00);
        add_command(lz8_pkg::CMD_BACK, 6, 1'b0, gen_wpos - lz8_pkg::t_waddr'(1),
                    8'h00, 8'h00);
        add_command(lz8_pkg::CMD_BACK_INV, 10, 1'b0, gen_wpos - lz8_pkg::t_waddr'(40),
                    8'h00, 8'h00);
        add_command(lz8_pkg::CMD_FILL, 260, 1'b1, '0, 8'h5A, 8'h00);
        end_stream();
        wait_drained();

        // backward distance zero reads the old entry, distance 255 in a long-form
        // inverted backward copy, an absolute offset of 0xffff, an empty stream
        write_base(16'h0100);
        add_command(lz8_pkg::CMD_BACK, 3, 1'b0, gen_wpos, 8'h00, 8'h00);
        add_command(lz8_pkg::CMD_BACK_INV, 40, 1'b1, gen_wpos - lz8_pkg::t_waddr'(255),
                    8'h00, 8'h00);
        add_command(lz8_pkg::CMD_COPY_INV, 4, 1'b0, lz8_pkg::t_waddr'(16'h00FF),
                    8'h00, 8'h00);
        end_stream();
        end_stream();
        wait_drained();

        for (i = 0; i < 5; i++) begin
            rnd_base = 16'($urandom);
            write_base((i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : rnd_base);
            add_random_phase(PHASE_BUDGET);
            wait_drained();
        end

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
